// ===== rtl/core/poe_pkg.sv =====
// poe_pkg: shared types, constants and helpers for the page ownership protocol engine
// depends on nothing; imported by the interfaces, the engine and its checker
package poe_pkg;

  localparam int PagesDef    = 256;
  localparam int MaxNodesDef = 16;

  localparam int KindW  = 3;
  localparam int PageW  = 8;
  localparam int NodeW  = 4;
  localparam int NcfgW  = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 5;
  localparam int LinkW  = 16;
  localparam int FinW   = 4;

  typedef enum logic [KindW-1:0] {
    KIND_FAULT     = 3'd0,
    KIND_ARRIVED   = 3'd1,
    KIND_REQUEST   = 3'd2,
    KIND_UPDATE    = 3'd3,
    KIND_PEER_FIN  = 3'd4,
    KIND_LINK_DOWN = 3'd5,
    KIND_LOCAL_FIN = 3'd6
  } evt_kind_e;

  typedef enum logic [1:0] {
    MSG_REQUEST  = 2'd0,
    MSG_PAGE     = 2'd1,
    MSG_UPDATE   = 2'd2,
    MSG_FINALIZE = 2'd3
  } msg_kind_e;

  typedef enum logic [1:0] {
    ST_OWNED     = 2'd0,
    ST_NOACCESS  = 2'd1,
    ST_REQUESTED = 2'd2
  } page_st_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_NODE_ID    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_MOD,
    FSM_EXEC,
    FSM_EMIT,
    FSM_BCAST
  } fsm_e;

  typedef struct packed {
    logic [NodeW-1:0] owner;
    page_st_e         st;
  } dir_entry_t;

  typedef struct packed {
    msg_kind_e        kind;
    logic [NodeW-1:0] dest;
    logic [PageW-1:0] page;
    logic [NodeW-1:0] origin;
  } msg_t;

  typedef struct packed {
    logic granted;
    logic must_wait;
    logic refetch;
    logic fault_error;
    logic barrier_done;
  } flags_t;

  // index of the lowest set bit, zero for an empty vector
  function automatic logic [NodeW-1:0] lowest_idx(input logic [LinkW-1:0] v);
    logic [NodeW-1:0] idx;
    idx = '0;
    for (int i = LinkW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = NodeW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/poe_if.sv =====
// poe_if: valid/ready channel interfaces for events, results and configuration writes
// depends on poe_pkg for field widths
interface poe_evt_if;
  import poe_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PageW-1:0] page;
  logic [NodeW-1:0] src;
  modport source (output valid, kind, page, src, input ready);
  modport sink (input valid, kind, page, src, output ready);
endinterface

interface poe_res_if;
  import poe_pkg::*;
  logic             valid;
  logic             ready;
  logic             msg_valid;
  logic [1:0]       msg_kind;
  logic [NodeW-1:0] msg_dest;
  logic [PageW-1:0] msg_page;
  logic [NodeW-1:0] msg_origin;
  logic             granted;
  logic             must_wait;
  logic             refetch;
  logic             fault_error;
  logic             barrier_done;
  logic             last;
  modport source (output valid, msg_valid, msg_kind, msg_dest, msg_page, msg_origin,
                  granted, must_wait, refetch, fault_error, barrier_done, last,
                  input ready);
  modport sink (input valid, msg_valid, msg_kind, msg_dest, msg_page, msg_origin,
                granted, must_wait, refetch, fault_error, barrier_done, last,
                output ready);
endinterface

interface poe_cfg_if;
  import poe_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/page_ownership_protocol_engine.sv =====
// page_ownership_protocol_engine: per-page owner directory and message sequencer
// depends on poe_pkg and the channel interfaces in poe_if.sv
//
//   channel  | dir | payload                                        | accepted when
//   ---------+-----+------------------------------------------------+---------------------
//   evt_i    | in  | kind, page, src                                | valid & ready
//   res_o    | out | msg_valid/kind/dest/page/origin, flags, last   | valid & ready
//   cfg_i    | in  | index (0 node_count, 1 node_id), data          | valid (ready tied 1)
//
// an event is accepted, then its remainder (page mod node_count) is formed one
// quotient bit per cycle through the subtract/compare unit, then it is decoded,
// then its results follow at one per cycle while res_o is not stalled: a single
// result, or up to fifteen messages for a broadcast
// evt_i.ready is high only while the sequencer is idle; results pass through a
// one-entry output register, so a stalled res_o only holds the sequencer
// reset leaves every page untouched (valid bits cleared at once, no sweep),
// all links alive, the finalize count at zero, node_count 2 and node_id 0
module page_ownership_protocol_engine #(
  parameter int PAGES     = poe_pkg::PagesDef,
  parameter int MAX_NODES = poe_pkg::MaxNodesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  poe_evt_if.sink   evt_i,
  poe_res_if.source res_o,
  poe_cfg_if.sink   cfg_i
);
  import poe_pkg::*;

  // only pages reachable by an 8-bit page number need directory storage
  localparam int DirDepthRaw = (PAGES < (1 << PageW)) ? PAGES : (1 << PageW);
  localparam int DirDepth    = (DirDepthRaw < 2) ? 2 : DirDepthRaw;
  localparam int DirAw       = $clog2(DirDepth);
  localparam int NodeLimit   = (MAX_NODES < LinkW) ? MAX_NODES : LinkW;

  // sequencer state
  fsm_e state_q, state_d;
  logic [KindW-1:0] kind_q;
  logic [PageW-1:0] page_q;
  logic [NodeW-1:0] src_q;
  logic [PageW-1:0] div_sh_q, div_sh_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [NodeW-1:0] rem_q, rem_d;

  // directory storage and valid bits
  dir_entry_t dir_mem [DirDepth];
  logic [DirDepth-1:0] touched_q;
  dir_entry_t rd_q;
  logic       rd_touched_q;
  logic       dir_we;
  dir_entry_t dir_wdata;
  logic [DirAw-1:0] dir_idx;

  // global protocol state and configuration
  logic [LinkW-1:0] link_q, link_d;
  logic [FinW-1:0]  fin_q, fin_d;
  logic [NcfgW-1:0] ncfg_q;
  logic [NodeW-1:0] nid_q;

  // pending results of the current event
  flags_t     flags_q, flags_d;
  logic       first_v_q, first_v_d;
  msg_t       first_q, first_d;
  msg_t       tmpl_q, tmpl_d;
  logic [LinkW-1:0] mask_q, mask_d;

  // output register
  logic       out_v_q, out_v_d;
  logic       out_mv_q, out_mv_d;
  msg_t       out_msg_q, out_msg_d;
  flags_t     out_flags_q, out_flags_d;
  logic       out_last_q, out_last_d;

  logic evt_acc;
  logic slot_free;
  logic [NcfgW-1:0] nc;
  logic [NcfgW-1:0] t_div;
  logic [LinkW-1:0] below_nc;
  logic [LinkW-1:0] me_bit, src_bit;
  logic       in_range, peer_ok;
  dir_entry_t cur;
  logic [LinkW-1:0] mask_rest;
  logic [FinW-1:0]  fin_new;

  assign evt_acc   = evt_i.valid && evt_i.ready;
  assign slot_free = !out_v_q || res_o.ready;
  assign dir_idx   = page_q[DirAw-1:0];

  // clamp node_count to 2..NodeLimit
  always_comb begin
    nc = ncfg_q;
    if (nc < NcfgW'(2)) begin
      nc = NcfgW'(2);
    end
    if (nc > NcfgW'(NodeLimit)) begin
      nc = NcfgW'(NodeLimit);
    end
  end

  always_comb begin
    for (int i = 0; i < LinkW; i++) begin
      below_nc[i] = (NcfgW'(i) < nc);
    end
  end

  assign me_bit   = LinkW'(1) << nid_q;
  assign src_bit  = LinkW'(1) << src_q;
  assign in_range = (32'(page_q) < PAGES);
  assign peer_ok  = ({1'b0, src_q} < nc) && (src_q != nid_q) && link_q[src_q];

  // one restoring remainder step per cycle
  assign t_div = {rem_q, div_sh_q[PageW-1]};

  // directory entry as seen after the remainder run; untouched pages get the default
  always_comb begin
    if (rd_touched_q) begin
      cur = rd_q;
    end else begin
      cur.owner = rem_q;
      cur.st    = (rem_q == nid_q) ? ST_OWNED : ST_NOACCESS;
    end
  end

  assign mask_rest = mask_q & (mask_q - LinkW'(1));
  assign fin_new   = (fin_q == '1) ? fin_q : fin_q + FinW'(1);

  always_comb begin
    state_d     = state_q;
    div_sh_d    = div_sh_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    link_d      = link_q;
    fin_d       = fin_q;
    flags_d     = flags_q;
    first_v_d   = first_v_q;
    first_d     = first_q;
    tmpl_d      = tmpl_q;
    mask_d      = mask_q;
    dir_we      = 1'b0;
    dir_wdata   = cur;
    out_v_d     = out_v_q && !res_o.ready;
    out_mv_d    = out_mv_q;
    out_msg_d   = out_msg_q;
    out_flags_d = out_flags_q;
    out_last_d  = out_last_q;

    case (state_q)
      FSM_IDLE: begin
        if (evt_acc) begin
          div_sh_d = evt_i.page;
          cnt_d    = '0;
          rem_d    = '0;
          state_d  = FSM_MOD;
        end
      end

      FSM_MOD: begin
        if (t_div >= nc) begin
          rem_d = NodeW'(t_div - nc);
        end else begin
          rem_d = t_div[NodeW-1:0];
        end
        div_sh_d = {div_sh_q[PageW-2:0], 1'b0};
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        flags_d   = '0;
        first_v_d = 1'b0;
        first_d   = '{kind: MSG_REQUEST, dest: '0, page: page_q, origin: nid_q};
        tmpl_d    = '{kind: MSG_UPDATE, dest: '0, page: page_q, origin: src_q};
        mask_d    = '0;
        state_d   = FSM_EMIT;
        case (kind_q)
          KIND_FAULT: begin
            if (!in_range) begin
              flags_d.fault_error = 1'b1;
            end else if (cur.st == ST_OWNED) begin
              flags_d.granted = 1'b1;
            end else if (cur.st == ST_REQUESTED) begin
              flags_d.must_wait = 1'b1;
            end else if (link_q[cur.owner]) begin
              first_v_d      = 1'b1;
              first_d.dest   = cur.owner;
              dir_we         = 1'b1;
              dir_wdata      = '{owner: cur.owner, st: ST_REQUESTED};
              flags_d.must_wait = 1'b1;
            end else begin
              flags_d.fault_error = 1'b1;
            end
          end
          KIND_ARRIVED: begin
            if (in_range && peer_ok) begin
              dir_we    = 1'b1;
              dir_wdata = '{owner: nid_q, st: ST_OWNED};
              flags_d.granted = 1'b1;
            end
          end
          KIND_REQUEST: begin
            if (in_range && peer_ok && (cur.owner == nid_q)) begin
              first_v_d    = 1'b1;
              first_d.kind = MSG_PAGE;
              first_d.dest = src_q;
              dir_we       = 1'b1;
              dir_wdata    = '{owner: src_q, st: ST_NOACCESS};
              // updates to every other live peer except the new owner
              mask_d       = link_q & below_nc & ~me_bit & ~src_bit;
            end
          end
          KIND_UPDATE: begin
            if (in_range && ({1'b0, src_q} < nc)) begin
              dir_we          = 1'b1;
              dir_wdata.owner = src_q;
              dir_wdata.st    = cur.st;
              if ((cur.st == ST_REQUESTED) && (src_q != nid_q)) begin
                dir_wdata.st    = ST_NOACCESS;
                flags_d.refetch = 1'b1;
              end
            end
          end
          KIND_PEER_FIN: begin
            if (peer_ok) begin
              fin_d = fin_new;
            end
          end
          KIND_LINK_DOWN: begin
            link_d = link_q & ~src_bit;
          end
          KIND_LOCAL_FIN: begin
            tmpl_d = '{kind: MSG_FINALIZE, dest: '0, page: '0, origin: nid_q};
            mask_d = link_q & below_nc & ~me_bit;
            if ((link_q & below_nc & ~me_bit) != '0) begin
              state_d = FSM_BCAST;
            end
          end
          default: begin
          end
        endcase
        // barrier reads the finalize count after this event
        flags_d.barrier_done = ({1'b0, fin_d} >= (nc - NcfgW'(1)));
      end

      FSM_EMIT: begin
        if (slot_free) begin
          out_v_d     = 1'b1;
          out_mv_d    = first_v_q;
          out_msg_d   = first_v_q ? first_q : '0;
          out_flags_d = flags_q;
          out_last_d  = (mask_q == '0);
          state_d     = (mask_q == '0) ? FSM_IDLE : FSM_BCAST;
        end
      end

      FSM_BCAST: begin
        if (slot_free) begin
          out_v_d        = 1'b1;
          out_mv_d       = 1'b1;
          out_msg_d      = tmpl_q;
          out_msg_d.dest = lowest_idx(mask_q);
          out_flags_d    = flags_q;
          out_last_d     = (mask_rest == '0);
          mask_d         = mask_rest;
          if (mask_rest == '0) begin
            state_d = FSM_IDLE;
          end
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      out_v_q   <= 1'b0;
      link_q    <= '1;
      fin_q     <= '0;
      ncfg_q    <= NcfgW'(2);
      nid_q     <= '0;
      touched_q <= '0;
      mask_q    <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      link_q  <= link_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      if (dir_we) begin
        touched_q[dir_idx] <= 1'b1;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_NODE_COUNT: ncfg_q <= cfg_i.data;
          CFG_NODE_ID:    nid_q  <= cfg_i.data[NodeW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    div_sh_q    <= div_sh_d;
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    flags_q     <= flags_d;
    first_v_q   <= first_v_d;
    first_q     <= first_d;
    tmpl_q      <= tmpl_d;
    out_mv_q    <= out_mv_d;
    out_msg_q   <= out_msg_d;
    out_flags_q <= out_flags_d;
    out_last_q  <= out_last_d;
    if (evt_acc) begin
      kind_q <= evt_i.kind;
      page_q <= evt_i.page;
      src_q  <= evt_i.src;
    end
  end

  // directory read on accept, write in the decode cycle
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      rd_q         <= dir_mem[evt_i.page[DirAw-1:0]];
      rd_touched_q <= touched_q[evt_i.page[DirAw-1:0]];
    end
    if (dir_we) begin
      dir_mem[dir_idx] <= dir_wdata;
    end
  end

  assign evt_i.ready = (state_q == FSM_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid        = out_v_q;
  assign res_o.msg_valid    = out_mv_q;
  assign res_o.msg_kind     = out_msg_q.kind;
  assign res_o.msg_dest     = out_msg_q.dest;
  assign res_o.msg_page     = out_msg_q.page;
  assign res_o.msg_origin   = out_msg_q.origin;
  assign res_o.granted      = out_flags_q.granted;
  assign res_o.must_wait    = out_flags_q.must_wait;
  assign res_o.refetch      = out_flags_q.refetch;
  assign res_o.fault_error  = out_flags_q.fault_error;
  assign res_o.barrier_done = out_flags_q.barrier_done;
  assign res_o.last         = out_last_q;

endmodule

// ===== rtl/core/poe_checker.sv =====
// poe_checker: port-level assertions for the page ownership protocol engine
// depends on poe_pkg; bound to page_ownership_protocol_engine below
module poe_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  evt_valid_i,
  input logic                  evt_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic                  msg_valid_i,
  input logic [1:0]            msg_kind_i,
  input logic [poe_pkg::NodeW-1:0] msg_dest_i,
  input logic [poe_pkg::PageW-1:0] msg_page_i,
  input logic [poe_pkg::NodeW-1:0] msg_origin_i,
  input logic                  granted_i,
  input logic                  must_wait_i,
  input logic                  refetch_i,
  input logic                  fault_error_i,
  input logic                  barrier_done_i,
  input logic                  last_i
);
  import poe_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable({msg_valid_i, msg_kind_i, msg_dest_i, msg_page_i, msg_origin_i,
               granted_i, must_wait_i, refetch_i, fault_error_i, barrier_done_i, last_i}))
    else $error("result changed while stalled");

  // a result without a message carries zero message fields
  a_empty_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !msg_valid_i |->
      msg_kind_i == '0 && msg_dest_i == '0 && msg_page_i == '0 && msg_origin_i == '0)
    else $error("message fields set on an empty result");

  // an empty result is the only result of its event
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !msg_valid_i |-> last_i)
    else $error("empty result not marked last");

  // at most one access outcome per event
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> $onehot0({granted_i, must_wait_i, refetch_i, fault_error_i}))
    else $error("conflicting access flags");

  // an accepted event keeps the engine busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event accepted back to back");

endmodule

bind page_ownership_protocol_engine poe_checker u_poe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .evt_valid_i    (evt_i.valid),
  .evt_ready_i    (evt_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .msg_valid_i    (res_o.msg_valid),
  .msg_kind_i     (res_o.msg_kind),
  .msg_dest_i     (res_o.msg_dest),
  .msg_page_i     (res_o.msg_page),
  .msg_origin_i   (res_o.msg_origin),
  .granted_i      (res_o.granted),
  .must_wait_i    (res_o.must_wait),
  .refetch_i      (res_o.refetch),
  .fault_error_i  (res_o.fault_error),
  .barrier_done_i (res_o.barrier_done),
  .last_i         (res_o.last)
);
